// ===== sv/dbpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dbpd_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned TIMER_BITS  = 16;
  localparam int unsigned THRESH_BITS = 10;
  localparam int unsigned WINDOW_BITS = 10;
  localparam int unsigned TOUT_BITS   = 16;
  localparam int unsigned DUR_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(100);
  localparam logic [TOUT_BITS-1:0]   TOUT_RESET   = TOUT_BITS'(2000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BEAM_THRESHOLD  = 2'd0,
    CFG_COINCIDE_WINDOW = 2'd1,
    CFG_BLOCK_TIMEOUT   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [THRESH_BITS-1:0] beam_threshold;
    logic [WINDOW_BITS-1:0] coincide_window;
    logic [TOUT_BITS-1:0]   block_timeout;
  } cfg_t;

  typedef struct packed {
    logic                pass_pulse;
    logic [DUR_BITS-1:0] contact_ms;
    logic                blocked;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/dbpd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbpd_cfg_regs
  import dbpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [CFG_IDX_BITS-1:0]  wr_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] wr_data_i,
  output cfg_t                          cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_BEAM_THRESHOLD:  cfg_d.beam_threshold  = wr_data_i[THRESH_BITS-1:0];
        CFG_COINCIDE_WINDOW: cfg_d.coincide_window = wr_data_i[WINDOW_BITS-1:0];
        CFG_BLOCK_TIMEOUT:   cfg_d.block_timeout   = wr_data_i[TOUT_BITS-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beam_threshold  <= THRESH_RESET;
      cfg_q.coincide_window <= WINDOW_RESET;
      cfg_q.block_timeout   <= TOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/dbpd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbpd_core
  import dbpd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_a_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_b_i,
  input  cfg_t                        cfg_i,
  output res_t                        res_o
);

  localparam int unsigned CmpW = (TIMER_BITS > TOUT_BITS) ? TIMER_BITS : TOUT_BITS;
  localparam int unsigned SatW = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;
  localparam int unsigned SmpW = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

  logic                   active_q, active_d;
  logic                   seen_q, seen_d;
  logic                   waiting_q, waiting_d;
  logic                   first_b_q, first_b_d;
  logic [WINDOW_BITS-1:0] window_q, window_d;
  logic [TIMER_BITS-1:0]  elapsed_q, elapsed_d;
  logic                   blocked_q, blocked_d;

  logic a_hi, b_hi, other, coincide, fail, pass, too_long;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [SatW-1:0]       dur_wide;

  assign a_hi = SmpW'(sample_a_i) > SmpW'(cfg_i.beam_threshold);
  assign b_hi = SmpW'(sample_b_i) > SmpW'(cfg_i.beam_threshold);
  assign other = first_b_q ? a_hi : b_hi;
  assign elapsed_inc = (active_q && (elapsed_q != '1)) ? elapsed_q + 1'b1 : elapsed_q;

  always_comb begin
    active_d  = active_q;
    seen_d    = seen_q;
    waiting_d = waiting_q;
    first_b_d = first_b_q;
    window_d  = window_q;
    elapsed_d = elapsed_inc;
    blocked_d = blocked_q;
    coincide  = 1'b0;
    fail      = 1'b0;
    pass      = 1'b0;
    too_long  = 1'b0;

    if (waiting_q) begin
      if (other) begin
        coincide  = 1'b1;
        waiting_d = 1'b0;
      end else begin
        window_d = window_q + 1'b1;
        fail     = (window_d >= cfg_i.coincide_window);
      end
    end else if (a_hi || b_hi) begin
      if (!active_q) begin
        active_d  = 1'b1;
        elapsed_d = '0;
        blocked_d = 1'b0;
      end
      if (a_hi && b_hi) begin
        coincide = 1'b1;
      end else begin
        waiting_d = 1'b1;
        first_b_d = b_hi;
        window_d  = '0;
      end
    end else if (active_q) begin
      fail = 1'b1;
    end

    too_long = (CmpW'(elapsed_d) > CmpW'(cfg_i.block_timeout)) || (elapsed_d == '1);

    if (coincide) begin
      seen_d = 1'b1;
      if (too_long) begin
        blocked_d = 1'b1;
      end
    end else if (fail) begin
      pass = seen_q;
    end

    if ((coincide && too_long) || (!coincide && fail)) begin
      active_d  = 1'b0;
      seen_d    = 1'b0;
      waiting_d = 1'b0;
      first_b_d = 1'b0;
      window_d  = '0;
    end
  end

  assign dur_wide = SatW'(elapsed_d);

  always_comb begin
    res_o.pass_pulse = pass;
    res_o.blocked    = blocked_d;
    if (!pass) begin
      res_o.contact_ms = '0;
    end else if (dur_wide > SatW'({DUR_BITS{1'b1}})) begin
      res_o.contact_ms = '1;
    end else begin
      res_o.contact_ms = dur_wide[DUR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      seen_q    <= 1'b0;
      waiting_q <= 1'b0;
      first_b_q <= 1'b0;
      window_q  <= '0;
      elapsed_q <= '0;
      blocked_q <= 1'b0;
    end else if (step_i) begin
      active_q  <= active_d;
      seen_q    <= seen_d;
      waiting_q <= waiting_d;
      first_b_q <= first_b_d;
      window_q  <= window_d;
      elapsed_q <= (active_d && !((coincide && too_long) || (!coincide && fail)))
                   ? elapsed_d : '0;
      blocked_q <= blocked_d;
    end
  end

  a_wait_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> active_q)
    else $error("window open without activity");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (elapsed_q == '0) && !seen_q && !waiting_q)
    else $error("idle state not cleared");

  a_pass_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.pass_pulse) |=> !active_q)
    else $error("activity survives pass");

  a_block_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !blocked_q && res_o.blocked) |=> !active_q)
    else $error("activity survives block");

endmodule

`default_nettype wire

// ===== sv/dual_beam_pass_detector.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | sample_a_i, sample_b_i
// out     | output    | out_valid_o / out_ready_i | pass_pulse_o, contact_ms_o, blocked_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word in, one word out; one word per cycle sustained while the output is not stalled.
// An accepted word gives a valid result after it passes through the
// input register and then the result register.
// The detector state advances when a word moves from the input register
// into the result register.
// A stalled output holds the result register and, once full, the input register;
// cfg is always ready.
// Reset: asynchronous, active low; clears valid flags and detector state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_beam_pass_detector
  import dbpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]   sample_a_i,
  input  wire logic [SAMPLE_BITS-1:0]   sample_b_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          pass_pulse_o,
  output logic [DUR_BITS-1:0]           contact_ms_o,
  output logic                          blocked_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t cfg;
  res_t res;
  res_t res_q;

  logic                   in_vld_q;
  logic [SAMPLE_BITS-1:0] a_q, b_q;
  logic                   out_vld_q;
  logic                   out_free, step;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || out_ready_i;
  assign step        = in_vld_q && out_free;
  assign in_ready_o  = !in_vld_q || out_free;

  dbpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dbpd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .sample_a_i (a_q),
    .sample_b_i (b_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= sample_a_i;
      b_q <= sample_b_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pass_pulse_o = res_q.pass_pulse;
  assign contact_ms_o = res_q.contact_ms;
  assign blocked_o    = res_q.blocked;

endmodule

`default_nettype wire
